### design/mitcfe_pkg.sv
// Shared types and constants for the MIT-mode command frame encoder.
// Command and frame words, register indexes, motor ranges and elaboration helpers.
// No dependencies.
package mitcfe_pkg;

  localparam int POSITION_CODE_BITS = 16;
  localparam int FIELD_CODE_BITS    = 12;

  localparam int POS_SLOT_BITS   = 16;
  localparam int FIELD_SLOT_BITS = 12;

  // motor ranges in input units
  localparam int POS_LIMIT = 12800;
  localparam int VEL_LIMIT = 11520;
  localparam int KP_MAX    = 32000;
  localparam int KD_MAX    = 20480;
  localparam int TRQ_LIMIT = 18432;

  localparam int VALUE_W     = 17;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENABLED         = 1'b0,
    REG_COMMAND_REVERSE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] position;
    logic signed [15:0] velocity;
    logic [15:0]        stiffness;
    logic [15:0]        damping;
    logic signed [15:0] torque;
  } cmd_t;

  typedef struct packed {
    logic [63:0] frame;
    logic        sent;
  } result_t;

  function automatic int trailing_zeros(longint v);
    int n;
    n = 0;
    for (int i = 0; i < 63; i++) begin
      if (v[i] == 1'b0 && n == i) n = i + 1;
    end
    return n;
  endfunction

  function automatic int max_int(int a, int b);
    return (a > b) ? a : b;
  endfunction

endpackage

### design/mitcfe_field_enc.sv
// One field of the command frame: clamp, offset and scale to an unsigned code.
// Division by the constant span is a shift plus a reciprocal multiply.
// Depends on mitcfe_pkg.
module mitcfe_field_enc #(
  parameter int BITS = mitcfe_pkg::FIELD_CODE_BITS,
  parameter int LO   = -mitcfe_pkg::VEL_LIMIT,
  parameter int HI   = mitcfe_pkg::VEL_LIMIT
) (
  input  logic signed [mitcfe_pkg::VALUE_W-1:0] value,
  output logic [BITS-1:0]                       code
);

  localparam longint SPAN  = longint'(HI) - longint'(LO);
  localparam longint DIV   = 2 * SPAN;
  localparam longint NMAX  = 2 * SPAN * ((64'(1) << BITS) - 1) + SPAN;
  localparam int     K     = mitcfe_pkg::trailing_zeros(DIV);
  localparam longint ODD   = DIV >> K;
  localparam int     OW    = $clog2(SPAN + 1);
  localparam int     NW    = $clog2(NMAX + 1);
  localparam int     XW    = NW - K;
  localparam int     S     = XW + $clog2(ODD);
  localparam longint RECIP = ((64'(1) << S) + ODD - 1) / ODD;
  localparam int     RW    = $clog2(RECIP + 1);
  localparam int     PW    = mitcfe_pkg::max_int(XW + RW, S + BITS);

  localparam logic signed [mitcfe_pkg::VALUE_W-1:0] LO_V = mitcfe_pkg::VALUE_W'(LO);
  localparam logic signed [mitcfe_pkg::VALUE_W-1:0] HI_V = mitcfe_pkg::VALUE_W'(HI);

  logic signed [mitcfe_pkg::VALUE_W-1:0] clamped;
  logic signed [mitcfe_pkg::VALUE_W-1:0] diff;
  logic [OW-1:0] off;
  logic [NW-1:0] off_w;
  logic [NW-1:0] num;
  logic [XW-1:0] x;
  logic [PW-1:0] prod;

  always_comb begin
    if (value < LO_V) begin
      clamped = LO_V;
    end else if (value > HI_V) begin
      clamped = HI_V;
    end else begin
      clamped = value;
    end
    diff  = clamped - LO_V;
    off   = diff[OW-1:0];
    off_w = NW'(off);
    // 2*off*(2^BITS-1) + span
    num   = (((off_w << BITS) - off_w) << 1) + NW'(SPAN);
    x     = num[NW-1:K];
    prod  = PW'(x) * PW'(RECIP);
    code  = prod[S +: BITS];
  end

endmodule

### design/mit_command_frame_encoder_unit.sv
// Top level of the MIT-mode command frame encoder.
// Registers the command word, encodes five fields and packs the 8-byte frame.
// Depends on mitcfe_pkg and mitcfe_field_enc.
//
//  channel  | signals                              | handshake
//  ---------+--------------------------------------+------------------------------
//  command  | start, busy, cmd                     | taken when start & !busy
//  result   | strobe, result                       | one-cycle strobe, no stall
//  config   | cfg_valid, cfg_ready, cfg_index/data | written when valid & ready
//
// One command per cycle; its result word passes the input register, then the result
// register, and strobes while the result register holds it.
// busy stays low: the receiver cannot stall, so nothing backs up. Synchronous reset
// clears enabled, command_reverse and the valid flags; a command that is encoded while
// enabled is low gives frame 0, sent 0.
module mit_command_frame_encoder_unit #(
  parameter int POSITION_CODE_BITS = mitcfe_pkg::POSITION_CODE_BITS,
  parameter int FIELD_CODE_BITS    = mitcfe_pkg::FIELD_CODE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  mitcfe_pkg::cmd_t                       cmd,
  output logic                                   strobe,
  output mitcfe_pkg::result_t                    result,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mitcfe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mitcfe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic enabled;
  logic command_reverse;
  logic in_valid;
  mitcfe_pkg::cmd_t in_cmd;
  logic out_valid;
  mitcfe_pkg::result_t out_word;
  mitcfe_pkg::result_t out_word_next;

  logic signed [mitcfe_pkg::VALUE_W-1:0] pos_w, vel_w, trq_w;
  logic signed [mitcfe_pkg::VALUE_W-1:0] pos_v, vel_v, trq_v, kp_v, kd_v;
  logic [POSITION_CODE_BITS-1:0] cp;
  logic [FIELD_CODE_BITS-1:0]    cv, ckp, ckd, ct;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign strobe    = out_valid;
  assign result    = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled         <= 1'b0;
      command_reverse <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mitcfe_pkg::REG_ENABLED:         enabled         <= cfg_data[0];
        mitcfe_pkg::REG_COMMAND_REVERSE: command_reverse <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_valid  <= start && !busy;
      out_valid <= in_valid;
    end
    if (start && !busy) in_cmd <= cmd;
    out_word <= out_word_next;
  end

  always_comb begin
    pos_w = {in_cmd.position[15], in_cmd.position};
    vel_w = {in_cmd.velocity[15], in_cmd.velocity};
    trq_w = {in_cmd.torque[15], in_cmd.torque};
    pos_v = command_reverse ? -pos_w : pos_w;
    vel_v = command_reverse ? -vel_w : vel_w;
    trq_v = command_reverse ? -trq_w : trq_w;
    kp_v  = {1'b0, in_cmd.stiffness};
    kd_v  = {1'b0, in_cmd.damping};
  end

  mitcfe_field_enc #(
    .BITS(POSITION_CODE_BITS), .LO(-mitcfe_pkg::POS_LIMIT), .HI(mitcfe_pkg::POS_LIMIT)
  ) u_pos (.value(pos_v), .code(cp));

  mitcfe_field_enc #(
    .BITS(FIELD_CODE_BITS), .LO(-mitcfe_pkg::VEL_LIMIT), .HI(mitcfe_pkg::VEL_LIMIT)
  ) u_vel (.value(vel_v), .code(cv));

  mitcfe_field_enc #(
    .BITS(FIELD_CODE_BITS), .LO(0), .HI(mitcfe_pkg::KP_MAX)
  ) u_kp (.value(kp_v), .code(ckp));

  mitcfe_field_enc #(
    .BITS(FIELD_CODE_BITS), .LO(0), .HI(mitcfe_pkg::KD_MAX)
  ) u_kd (.value(kd_v), .code(ckd));

  mitcfe_field_enc #(
    .BITS(FIELD_CODE_BITS), .LO(-mitcfe_pkg::TRQ_LIMIT), .HI(mitcfe_pkg::TRQ_LIMIT)
  ) u_trq (.value(trq_v), .code(ct));

  always_comb begin
    if (enabled) begin
      out_word_next.frame = {mitcfe_pkg::POS_SLOT_BITS'(cp),
                             mitcfe_pkg::FIELD_SLOT_BITS'(cv),
                             mitcfe_pkg::FIELD_SLOT_BITS'(ckp),
                             mitcfe_pkg::FIELD_SLOT_BITS'(ckd),
                             mitcfe_pkg::FIELD_SLOT_BITS'(ct)};
      out_word_next.sent  = 1'b1;
    end else begin
      out_word_next.frame = '0;
      out_word_next.sent  = 1'b0;
    end
  end

endmodule
